[design/dmm_pkg.sv]
// dmm_pkg: shared constants, command codes, queue entry and status types
// for the dense matrix multiply block. No dependencies.
`default_nettype none
package dmm_pkg;

  localparam int MAX_SIZE = 64;
  localparam int MAX_COLS = 8;

  localparam int ROW_W   = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int COL_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int N_W     = ROW_W + 1;
  localparam int IDX_W   = 6;
  localparam int OCOL_W  = 3;
  localparam int SIZE_W  = 7;
  localparam int COLS_W  = 4;
  localparam int VAL_W   = 32;
  localparam int PROD_W  = 2 * VAL_W;
  localparam int FRAC_W  = 16;
  localparam int ACC_W   = PROD_W + ROW_W + 1;
  localparam int RND_W   = ACC_W - FRAC_W;

  localparam int MAT_AW  = 2 * ROW_W;
  localparam int OPD_AW  = ROW_W + COL_W;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic REG_SIZE = 1'b0;
  localparam logic REG_COLS = 1'b1;

  typedef enum logic [1:0] {
    CMD_LOAD_MAT = 2'd0,
    CMD_LOAD_OPD = 2'd1,
    CMD_COMPUTE  = 2'd2,
    CMD_UNUSED   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    B_IDLE  = 2'd0,
    B_MAC   = 2'd1,
    B_ROUND = 2'd2,
    B_EMIT  = 2'd3
  } back_state_t;

  typedef struct packed {
    cmd_t              op;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [VAL_W-1:0]  value;
    logic [N_W-1:0]    n;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage
`default_nettype wire

[design/dmm_front.sv]
// dmm_front: configuration registers, request acceptance and classification.
// Depends on dmm_pkg; feeds dmm_queue.
`default_nettype none
module dmm_front import dmm_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        in_cmd,
  input  wire logic [IDX_W-1:0]  in_row_index,
  input  wire logic [IDX_W-1:0]  in_col_index,
  input  wire logic [VAL_W-1:0]  in_entry_value,
  input  wire q_status_t         q_status,
  output logic                   q_push,
  output q_entry_t               q_wdata
);

  logic [SIZE_W-1:0] size_r;
  logic [COLS_W-1:0] cols_r;
  logic              cfg_we;
  logic [31:0]       n_eff;
  logic [31:0]       w_eff;
  logic [31:0]       row_ext;
  logic [31:0]       col_ext;
  logic              keep;
  cmd_t              cmd;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_W'(64);
      cols_r <= COLS_W'(8);
    end else if (cfg_we) begin
      unique case (paddr[2])
        REG_SIZE: size_r <= pwdata[SIZE_W-1:0];
        REG_COLS: cols_r <= pwdata[COLS_W-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_SIZE: prdata = APB_DW'(size_r);
      REG_COLS: prdata = APB_DW'(cols_r);
      default:  prdata = '0;
    endcase
  end

  assign cmd     = cmd_t'(in_cmd);
  assign row_ext = 32'(in_row_index);
  assign col_ext = 32'(in_col_index);
  assign n_eff   = (32'(size_r) > 32'(MAX_SIZE)) ? 32'(MAX_SIZE) : 32'(size_r);
  assign w_eff   = (32'(cols_r) > 32'(MAX_COLS)) ? 32'(MAX_COLS) : 32'(cols_r);

  always_comb begin
    unique case (cmd)
      CMD_LOAD_MAT: keep = (row_ext < 32'(MAX_SIZE)) && (col_ext < 32'(MAX_SIZE));
      CMD_LOAD_OPD: keep = (row_ext < 32'(MAX_SIZE)) && (col_ext < 32'(MAX_COLS));
      CMD_COMPUTE:  keep = (row_ext < n_eff) && (col_ext < w_eff);
      default:      keep = 1'b0;
    endcase
  end

  assign in_stall      = q_status.full;
  assign q_push        = in_valid && !in_stall && keep;
  assign q_wdata.op    = cmd;
  assign q_wdata.row   = in_row_index;
  assign q_wdata.col   = in_col_index;
  assign q_wdata.value = in_entry_value;
  assign q_wdata.n     = N_W'(n_eff);

endmodule
`default_nettype wire

[design/dmm_queue.sv]
// dmm_queue: short request queue between front and back.
// Depends on dmm_pkg.
`default_nettype none
module dmm_queue import dmm_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire q_entry_t  wdata,
  input  wire logic      pop,
  output q_entry_t       head,
  output q_status_t      status
);

  q_entry_t          slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign status.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign status.empty = (count_r == '0);
  assign head         = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= wdata;
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !status.full) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !status.empty) else $error("pop from empty queue");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH)) else $error("queue count overflow");

endmodule
`default_nettype wire

[design/dmm_back.sv]
// dmm_back: matrix and operand stores, multiply-accumulate sequencer,
// rounding, saturation and output register. Depends on dmm_pkg.
`default_nettype none
module dmm_back import dmm_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire q_entry_t          head,
  input  wire q_status_t         q_status,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [VAL_W-1:0]       out_product_value,
  output logic [IDX_W-1:0]       out_product_row,
  output logic [OCOL_W-1:0]      out_product_column,
  output logic                   out_saturated
);

  logic [VAL_W-1:0] mat_mem [MAX_SIZE*MAX_SIZE];
  logic [VAL_W-1:0] opd_mem [MAX_SIZE*MAX_COLS];

  back_state_t        state_r, state_nxt;
  logic [IDX_W-1:0]   row_r;
  logic [IDX_W-1:0]   col_r;
  logic [N_W-1:0]     n_r;
  logic [N_W-1:0]     issue_r;
  logic               rd_v_r;
  logic               mul_v_r;
  logic [VAL_W-1:0]   mat_rdata_r;
  logic [VAL_W-1:0]   opd_rdata_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [ACC_W-1:0]   acc_r;
  logic [RND_W-1:0]   rnd_r;
  logic               out_valid_r;
  logic [VAL_W-1:0]   out_value_r;
  logic [IDX_W-1:0]   out_row_r;
  logic [OCOL_W-1:0]  out_col_r;
  logic               out_sat_r;

  logic               mat_we;
  logic               opd_we;
  logic               rd_en;
  logic               start;
  logic               out_load;
  logic [MAT_AW-1:0]  mat_waddr;
  logic [OPD_AW-1:0]  opd_waddr;
  logic [MAT_AW-1:0]  mat_raddr;
  logic [OPD_AW-1:0]  opd_raddr;
  logic [ACC_W-1:0]   rnd_sum;
  logic               fits;
  logic [VAL_W-1:0]   clip_value;

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    mat_we    = 1'b0;
    opd_we    = 1'b0;
    rd_en     = 1'b0;
    start     = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        if (!q_status.empty) begin
          q_pop = 1'b1;
          case (head.op)
            CMD_LOAD_MAT: mat_we = 1'b1;
            CMD_LOAD_OPD: opd_we = 1'b1;
            CMD_COMPUTE: begin
              start     = 1'b1;
              state_nxt = B_MAC;
            end
            default: ;
          endcase
        end
      end
      B_MAC: begin
        rd_en = (issue_r != n_r);
        if ((issue_r == n_r) && !rd_v_r && !mul_v_r) state_nxt = B_ROUND;
      end
      B_ROUND: state_nxt = B_EMIT;
      B_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      rd_v_r      <= 1'b0;
      mul_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rd_v_r  <= rd_en;
      mul_v_r <= rd_v_r;
      if (out_load)       out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  assign mat_waddr = {ROW_W'(head.row), ROW_W'(head.col)};
  assign opd_waddr = {ROW_W'(head.row), COL_W'(head.col)};
  assign mat_raddr = {ROW_W'(row_r), issue_r[ROW_W-1:0]};
  assign opd_raddr = {issue_r[ROW_W-1:0], COL_W'(col_r)};

  always_ff @(posedge clk) begin
    if (mat_we) mat_mem[mat_waddr] <= head.value;
    mat_rdata_r <= mat_mem[mat_raddr];
  end

  always_ff @(posedge clk) begin
    if (opd_we) opd_mem[opd_waddr] <= head.value;
    opd_rdata_r <= opd_mem[opd_raddr];
  end

  // rounding: add half an LSB of Q16.16, keep the bits above the fraction
  assign rnd_sum = acc_r + {{(ACC_W-FRAC_W){1'b0}}, 1'b1, {(FRAC_W-1){1'b0}}};
  assign fits    = (&rnd_r[RND_W-1:VAL_W-1]) || !(|rnd_r[RND_W-1:VAL_W-1]);
  assign clip_value = rnd_r[RND_W-1] ? {1'b1, {(VAL_W-1){1'b0}}}
                                     : {1'b0, {(VAL_W-1){1'b1}}};

  always_ff @(posedge clk) begin
    if (start) begin
      row_r   <= head.row;
      col_r   <= head.col;
      n_r     <= head.n;
      issue_r <= '0;
      acc_r   <= '0;
    end else begin
      if (rd_en)   issue_r <= issue_r + 1'b1;
      if (mul_v_r) acc_r   <= acc_r + {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
    end
    prod_r <= $signed(mat_rdata_r) * $signed(opd_rdata_r);
    if (state_r == B_ROUND) rnd_r <= rnd_sum[ACC_W-1:FRAC_W];
    if (out_load) begin
      out_value_r <= fits ? rnd_r[VAL_W-1:0] : clip_value;
      out_sat_r   <= !fits;
      out_row_r   <= row_r;
      out_col_r   <= col_r[OCOL_W-1:0];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_product_value  = out_value_r;
  assign out_product_row    = out_row_r;
  assign out_product_column = out_col_r;
  assign out_saturated      = out_sat_r;

  a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_MAC) |-> (issue_r <= n_r)) else $error("issue count past length");
  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_MAC) |-> (n_r != '0)) else $error("compute with zero length");
  a_round_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_ROUND) |-> (!rd_v_r && !mul_v_r)) else $error("round before drain");

endmodule
`default_nettype wire

[design/dense_matrix_multiply.sv]
// Dense matrix multiply top level: front (config, classify), request queue, back (MAC).
// Throughput: the back finishes one compute before it takes the next request,
// with one MAC per cycle over the row; loads are taken one per cycle while it is idle.
// The queue holds four requests, so loads and computes are taken while the back is busy.
// Reset: synchronous active-low; clears control, size 64, columns 8; stores stay undefined.
// Depends on dmm_pkg, dmm_front, dmm_queue, dmm_back.
`default_nettype none
module dense_matrix_multiply import dmm_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        in_cmd,
  input  wire logic [IDX_W-1:0]  in_row_index,
  input  wire logic [IDX_W-1:0]  in_col_index,
  input  wire logic [VAL_W-1:0]  in_entry_value,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [VAL_W-1:0]       out_product_value,
  output logic [IDX_W-1:0]       out_product_row,
  output logic [OCOL_W-1:0]      out_product_column,
  output logic                   out_saturated
);

  q_status_t q_status;
  q_entry_t  q_wdata;
  q_entry_t  q_head;
  logic      q_push;
  logic      q_pop;

  dmm_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_row_index   (in_row_index),
    .in_col_index   (in_col_index),
    .in_entry_value (in_entry_value),
    .q_status       (q_status),
    .q_push         (q_push),
    .q_wdata        (q_wdata)
  );

  dmm_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .pop    (q_pop),
    .head   (q_head),
    .status (q_status)
  );

  dmm_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head               (q_head),
    .q_status           (q_status),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_product_value  (out_product_value),
    .out_product_row    (out_product_row),
    .out_product_column (out_product_column),
    .out_saturated      (out_saturated)
  );

endmodule
`default_nettype wire
